// File: sv/iqfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqfs_pkg - shared types and constants for the I/Q phasor frequency shifter
// Controller states, command and status bundles, register map and sizes.
// ----------------------------------------------------------------------------
package iqfs_pkg;

   localparam int PH_W        = 18;                // Q2.16 phasor and step width
   localparam int SMP_W       = 8;                 // raw and mixed sample width
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam int ROOT_STEPS  = 18;                // result bits of the square root
   localparam int DIV_STEPS   = 34;                // dividend bits of the normaliser
   localparam int CNT_W       = $clog2(DIV_STEPS);

   localparam logic signed [PH_W-1:0] PH_ONE = 18'sd65536;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_INVERT_IQ = 2'd0;
   localparam logic [1:0] REG_STEP_REAL = 2'd1;
   localparam logic [1:0] REG_STEP_IMAG = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_MIX,
      ST_SQUARE,
      ST_SQ_SUM,
      ST_ROOT,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_NORM
   } state_type;

   typedef struct packed {
      logic load;        // capture the accepted sample
      logic mul;         // register mixing and rotation products
      logic mix;         // load result, advance phasor
      logic square;      // register squares of the phasor parts
      logic root_load;   // start square root
      logic root_step;   // one root iteration
      logic div_load;    // start both division lanes
      logic div_step;    // one division iteration
      logic norm;        // write the normalised phasor
   } cmd_type;

   typedef struct packed {
      logic mag_zero;    // square root came out zero
   } status_type;

endpackage

// File: sv/iqfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqfs_ctrl - sequencer for the I/Q phasor frequency shifter
// Walks each sample through multiply and mix, and runs the block-end
// renormalisation (square, root, divide) when the sample closes a block.
// ----------------------------------------------------------------------------
module iqfs_ctrl
   import iqfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_last_in_block,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last_in_block;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.mix      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = last_ff ? ST_SQUARE : ST_IDLE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            cmd.root_load = 1'b1;
            cnt_in        = CNT_W'(ROOT_STEPS - 1);
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DIV_LOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV_LOAD: begin
            // zero magnitude needs no division
            cmd.div_load = 1'b1;
            cnt_in       = CNT_W'(DIV_STEPS - 1);
            state_in     = status.mag_zero ? ST_NORM : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_NORM;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/iqfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqfs_datapath - arithmetic and state of the I/Q phasor frequency shifter
// Configuration registers, phasor, mixer products, result register, and a
// bit-serial square root and two restoring division lanes for renormalising.
// ----------------------------------------------------------------------------
module iqfs_datapath
   import iqfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [SMP_W-1:0]        req_i_raw,
   input  logic [SMP_W-1:0]        req_q_raw,
   output logic signed [SMP_W-1:0] rsp_i_out,
   output logic signed [SMP_W-1:0] rsp_q_out,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata
);

   function automatic logic signed [SMP_W-1:0] sat8(input logic signed [11:0] x);
      if (x > 12'sd127) begin
         return 8'sd127;
      end else if (x < -12'sd128) begin
         return -8'sd128;
      end
      return x[7:0];
   endfunction

   function automatic logic signed [PH_W-1:0] sat18(input logic signed [20:0] x);
      if (x > 21'sd131071) begin
         return 18'sd131071;
      end else if (x < -21'sd131072) begin
         return -18'sd131072;
      end
      return x[17:0];
   endfunction

   // quotient back to a signed part, saturated
   function automatic logic signed [PH_W-1:0] norm_part(input logic neg,
                                                        input logic [DIV_STEPS-1:0] q);
      if (neg) begin
         if (q > 34'd131072) begin
            return -18'sd131072;
         end
         return -signed'(q[17:0]);
      end
      if (q > 34'd131071) begin
         return 18'sd131071;
      end
      return signed'(q[17:0]);
   endfunction

   // configuration
   logic                   invert_ff, invert_in;
   logic signed [PH_W-1:0] step_re_ff, step_re_in;
   logic signed [PH_W-1:0] step_im_ff, step_im_in;
   logic                   csr_wr;
   logic [1:0]             csr_idx;

   // phasor
   logic signed [PH_W-1:0] ph_re_ff, ph_re_in;
   logic signed [PH_W-1:0] ph_im_ff, ph_im_in;

   // sample and products
   logic signed [8:0]  ci_ff, ci_in;
   logic signed [8:0]  cq_ff, cq_in;
   logic signed [7:0]  ci_c, cq_c;
   logic signed [26:0] m_ci_pr_ff, m_ci_pi_ff, m_cq_pr_ff, m_cq_pi_ff;
   logic signed [35:0] m_pr_sr_ff, m_pi_si_ff, m_pr_si_ff, m_pi_sr_ff;
   logic signed [27:0] mix_re, mix_im;
   logic signed [34:0] sc_re, sc_im, tb_re, tb_im;
   logic signed [36:0] adv_re, adv_im;
   logic signed [SMP_W-1:0] out_i_ff, out_q_ff;

   // renormalisation
   logic [34:0]              sq_re_ff, sq_im_ff;
   logic signed [35:0]       sq_re_full, sq_im_full;
   logic [35:0]              root_v_ff, root_v_in;
   logic [36:0]              root_r_ff, root_r_in;
   logic [35:0]              root_bit_ff, root_bit_in;
   logic [36:0]              trial;
   logic [PH_W-1:0]          divisor;
   logic [PH_W-1:0]          mag_re, mag_im;
   logic                     neg_re_ff, neg_im_ff;
   logic [DIV_STEPS-1:0]     num_re_ff, num_re_in, num_im_ff, num_im_in;
   logic [PH_W-1:0]          rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [PH_W:0]            t_re, t_im;
   logic                     ge_re, ge_im;

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];

   // ---------------- configuration ----------------
   always_comb begin
      invert_in  = invert_ff;
      step_re_in = step_re_ff;
      step_im_in = step_im_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_INVERT_IQ: invert_in  = csr_pwdata[0];
            REG_STEP_REAL: step_re_in = signed'(csr_pwdata[PH_W-1:0]);
            REG_STEP_IMAG: step_im_in = signed'(csr_pwdata[PH_W-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_INVERT_IQ: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, invert_ff};
         REG_STEP_REAL: csr_prdata = CSR_DATA_W'(step_re_ff);
         REG_STEP_IMAG: csr_prdata = CSR_DATA_W'(step_im_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- sample capture ----------------
   always_comb begin
      ci_c  = signed'({~req_i_raw[7], req_i_raw[6:0]});
      cq_c  = signed'({~req_q_raw[7], req_q_raw[6:0]});
      ci_in = 9'(ci_c);
      cq_in = invert_ff ? -9'(cq_c) : 9'(cq_c);
   end

   // ---------------- mix and advance ----------------
   always_comb begin
      mix_re = 28'(m_ci_pr_ff) - 28'(m_cq_pi_ff);
      mix_im = 28'(m_ci_pi_ff) + 28'(m_cq_pr_ff);
      sc_re  = (35'(mix_re) <<< 7) - 35'(mix_re);
      sc_im  = (35'(mix_im) <<< 7) - 35'(mix_im);
      // bias negatives so the shift truncates toward zero
      tb_re  = (sc_re + (sc_re[34] ? 35'sd8388607 : 35'sd0)) >>> 23;
      tb_im  = (sc_im + (sc_im[34] ? 35'sd8388607 : 35'sd0)) >>> 23;
      // round half up: add half, then floor
      adv_re = (37'(m_pr_sr_ff) - 37'(m_pi_si_ff) + 37'sd32768) >>> 16;
      adv_im = (37'(m_pr_si_ff) + 37'(m_pi_sr_ff) + 37'sd32768) >>> 16;
   end

   // ---------------- square root ----------------
   always_comb begin
      sq_re_full  = ph_re_ff * ph_re_ff;
      sq_im_full  = ph_im_ff * ph_im_ff;
      trial       = root_r_ff + {1'b0, root_bit_ff};
      root_v_in   = root_v_ff;
      root_r_in   = root_r_ff;
      root_bit_in = root_bit_ff;
      if (cmd.root_load) begin
         root_v_in   = 36'(sq_re_ff) + 36'(sq_im_ff);
         root_r_in   = '0;
         root_bit_in = 36'd1 << (2 * (ROOT_STEPS - 1));
      end else if (cmd.root_step) begin
         if ({1'b0, root_v_ff} >= trial) begin
            root_v_in = root_v_ff - trial[35:0];
            root_r_in = (root_r_ff >> 1) + {1'b0, root_bit_ff};
         end else begin
            root_r_in = root_r_ff >> 1;
         end
         root_bit_in = root_bit_ff >> 2;
      end
   end

   assign divisor         = root_r_ff[PH_W-1:0];
   assign status.mag_zero = (root_r_ff == '0);

   // ---------------- division lanes ----------------
   always_comb begin
      mag_re    = ph_re_ff[PH_W-1] ? PH_W'(-ph_re_ff) : PH_W'(ph_re_ff);
      mag_im    = ph_im_ff[PH_W-1] ? PH_W'(-ph_im_ff) : PH_W'(ph_im_ff);
      t_re      = {rem_re_ff, num_re_ff[DIV_STEPS-1]};
      t_im      = {rem_im_ff, num_im_ff[DIV_STEPS-1]};
      ge_re     = t_re >= {1'b0, divisor};
      ge_im     = t_im >= {1'b0, divisor};
      num_re_in = num_re_ff;
      num_im_in = num_im_ff;
      rem_re_in = rem_re_ff;
      rem_im_in = rem_im_ff;
      if (cmd.div_load) begin
         // part * 65536 plus half the divisor, for round to nearest
         num_re_in = {mag_re, 16'd0} + DIV_STEPS'(divisor >> 1);
         num_im_in = {mag_im, 16'd0} + DIV_STEPS'(divisor >> 1);
         rem_re_in = '0;
         rem_im_in = '0;
      end else if (cmd.div_step) begin
         num_re_in = {num_re_ff[DIV_STEPS-2:0], ge_re};
         num_im_in = {num_im_ff[DIV_STEPS-2:0], ge_im};
         rem_re_in = ge_re ? PH_W'(t_re - {1'b0, divisor}) : t_re[PH_W-1:0];
         rem_im_in = ge_im ? PH_W'(t_im - {1'b0, divisor}) : t_im[PH_W-1:0];
      end
   end

   // ---------------- phasor ----------------
   always_comb begin
      ph_re_in = ph_re_ff;
      ph_im_in = ph_im_ff;
      priority if (csr_wr && (csr_idx == REG_STEP_REAL || csr_idx == REG_STEP_IMAG)) begin
         ph_re_in = PH_ONE;
         ph_im_in = '0;
      end else if (cmd.mix) begin
         ph_re_in = sat18(adv_re[20:0]);
         ph_im_in = sat18(adv_im[20:0]);
      end else if (cmd.norm) begin
         if (status.mag_zero) begin
            ph_re_in = PH_ONE;
            ph_im_in = '0;
         end else begin
            ph_re_in = norm_part(neg_re_ff, num_re_ff);
            ph_im_in = norm_part(neg_im_ff, num_im_ff);
         end
      end else begin
         // hold
         ph_re_in = ph_re_ff;
         ph_im_in = ph_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff  <= 1'b0;
         step_re_ff <= PH_ONE;
         step_im_ff <= '0;
         ph_re_ff   <= PH_ONE;
         ph_im_ff   <= '0;
      end else begin
         invert_ff  <= invert_in;
         step_re_ff <= step_re_in;
         step_im_ff <= step_im_in;
         ph_re_ff   <= ph_re_in;
         ph_im_ff   <= ph_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ci_ff <= ci_in;
         cq_ff <= cq_in;
      end
      if (cmd.mul) begin
         m_ci_pr_ff <= ci_ff * ph_re_ff;
         m_ci_pi_ff <= ci_ff * ph_im_ff;
         m_cq_pr_ff <= cq_ff * ph_re_ff;
         m_cq_pi_ff <= cq_ff * ph_im_ff;
         m_pr_sr_ff <= ph_re_ff * step_re_ff;
         m_pi_si_ff <= ph_im_ff * step_im_ff;
         m_pr_si_ff <= ph_re_ff * step_im_ff;
         m_pi_sr_ff <= ph_im_ff * step_re_ff;
      end
      if (cmd.mix) begin
         out_i_ff <= sat8(tb_re[11:0]);
         out_q_ff <= sat8(tb_im[11:0]);
      end
      if (cmd.square) begin
         sq_re_ff <= sq_re_full[34:0];
         sq_im_ff <= sq_im_full[34:0];
      end
      if (cmd.div_load) begin
         neg_re_ff <= ph_re_ff[PH_W-1];
         neg_im_ff <= ph_im_ff[PH_W-1];
      end
      root_v_ff   <= root_v_in;
      root_r_ff   <= root_r_in;
      root_bit_ff <= root_bit_in;
      num_re_ff   <= num_re_in;
      num_im_ff   <= num_im_in;
      rem_re_ff   <= rem_re_in;
      rem_im_ff   <= rem_im_in;
   end

   assign rsp_i_out = out_i_ff;
   assign rsp_q_out = out_q_ff;

endmodule

// File: sv/iq_phasor_frequency_shifter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_phasor_frequency_shifter_top - complex NCO mixer for 8-bit I/Q samples
// Each sample is loaded, multiplied and mixed, and the result is registered;
// mixing waits while the output register is full. A new sample is taken
// only when idle. A block's last sample adds the 18-step square root and
// the 34-step division lanes that renormalise the phasor (no division on zero).
// Reset: synchronous; step becomes 1+0j, phasor 1+0j, inversion off.
// ----------------------------------------------------------------------------
module iq_phasor_frequency_shifter_top
   import iqfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SMP_W-1:0]        req_i_raw,
   input  logic [SMP_W-1:0]        req_q_raw,
   input  logic                    req_last_in_block,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SMP_W-1:0] rsp_i_out,
   output logic signed [SMP_W-1:0] rsp_q_out,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   iqfs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_last_in_block (req_last_in_block),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .status            (status),
      .cmd               (cmd)
   );

   iqfs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_i_raw   (req_i_raw),
      .req_q_raw   (req_q_raw),
      .rsp_i_out   (rsp_i_out),
      .rsp_q_out   (rsp_q_out),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule
